>>> sv/bse_pkg.sv
// Shared constants, types and codes of the bit set engine.
package bse_pkg;

    localparam int BSE_N_BITS_DEF = 1024;  // default set capacity in bits
    localparam int BSE_WORD_W     = 64;    // storage word width
    localparam int BSE_OP_W       = 4;
    localparam int BSE_POS_W      = 11;
    localparam int BSE_ACT_W      = 11;
    localparam int BSE_CNT_W      = 11;
    localparam int BSE_FPOS_W     = 10;

    localparam logic [BSE_ACT_W-1:0] BSE_ACT_RST = 11'd1024;

    typedef enum logic [BSE_OP_W-1:0] {
        OP_SET       = 4'd0,
        OP_CLR       = 4'd1,
        OP_FLIP      = 4'd2,
        OP_TEST      = 4'd3,
        OP_SHL       = 4'd4,
        OP_SHR       = 4'd5,
        OP_CLR_ALL   = 4'd6,
        OP_COUNT     = 4'd7,
        OP_FIND_FST  = 4'd8,
        OP_FIND_NXT  = 4'd9
    } t_opcode;

    typedef struct packed {
        logic                  bit_value;
        logic [BSE_CNT_W-1:0]  ones_count;
        logic                  found;
        logic [BSE_FPOS_W-1:0] found_position;
        logic                  out_of_range;
    } t_res;

endpackage

>>> sv/bse_if.sv
// Command and result channel interfaces of the bit set engine.
interface bse_cmd_if import bse_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BSE_OP_W-1:0]  opcode;
    logic [BSE_POS_W-1:0] bit_position;

    modport source (output valid, output opcode, output bit_position, input ready);
    modport sink   (input valid, input opcode, input bit_position, output ready);
endinterface

interface bse_res_if import bse_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  bit_value;
    logic [BSE_CNT_W-1:0]  ones_count;
    logic                  found;
    logic [BSE_FPOS_W-1:0] found_position;
    logic                  out_of_range;

    modport source (output valid, output bit_value, output ones_count, output found,
                    output found_position, output out_of_range, input ready);
    modport sink   (input valid, input bit_value, input ones_count, input found,
                    input found_position, input out_of_range, output ready);
endinterface

>>> sv/bse_ram.sv
// Word store of the bit set: one write and one registered read per cycle.
module bse_ram import bse_pkg::*; #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                  i_clk,
    input  logic                  i_re,
    input  logic [ADDR_W-1:0]     i_raddr,
    output logic [BSE_WORD_W-1:0] o_rdata,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  logic [BSE_WORD_W-1:0] i_wdata
);

    logic [BSE_WORD_W-1:0] r_mem [DEPTH];
    logic [BSE_WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bse_seq.sv
// Command sequencer: read-modify-write of single bits, word sweeps and scans.
module bse_seq import bse_pkg::*; #(
    parameter int WORD_COUNT = 16,
    parameter int ADDR_W     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  logic [BSE_OP_W-1:0]   i_opcode,
    input  logic [BSE_POS_W-1:0]  i_bit_position,
    // configuration
    input  logic [BSE_ACT_W-1:0]  i_used,
    input  logic                  i_cfg_we,
    input  logic [BSE_ACT_W-1:0]  i_cfg_used,
    // result
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_res                  o_res,
    // word store
    output logic                  o_ram_re,
    output logic [ADDR_W-1:0]     o_ram_raddr,
    input  logic [BSE_WORD_W-1:0] i_ram_rdata,
    output logic                  o_ram_we,
    output logic [ADDR_W-1:0]     o_ram_waddr,
    output logic [BSE_WORD_W-1:0] o_ram_wdata
);

    localparam int KW   = $clog2(WORD_COUNT + 2);
    localparam int SUMW = ((KW > 5) ? KW : 5) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_BIT,
        S_SWEEP,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [KW-1:0]          r_k, n_k;
    logic                   r_step_v, n_step_v;
    logic [KW-1:0]          r_k_d, n_k_d;
    logic                   r_rd_ok, n_rd_ok;
    logic [BSE_WORD_W-1:0]  r_prev, n_prev;
    t_res                   r_res, n_res;
    t_opcode                r_op, n_op;
    logic [BSE_POS_W-1:0]   r_pos, n_pos;
    logic                   r_dir_up, n_dir_up;
    logic [4:0]             r_q, n_q;
    logic [5:0]             r_r, n_r;
    logic [BSE_ACT_W-1:0]   r_lim, n_lim;
    logic [4:0]             r_sw, n_sw;
    logic [5:0]             r_sb, n_sb;
    logic                   r_has_res, n_has_res;

    logic [BSE_WORD_W-1:0]  w_cur;
    logic [SUMW-1:0]        w_sum;
    logic                   w_src_ok;
    logic [ADDR_W-1:0]      w_src_addr;
    logic [ADDR_W-1:0]      w_dest;
    logic [BSE_WORD_W-1:0]  w_shift;
    logic [BSE_WORD_W-1:0]  w_bit_mask;
    logic [BSE_WORD_W-1:0]  w_scan_word;
    logic [ADDR_W+5:0]      w_fpos;
    logic [BSE_POS_W:0]     w_next_start;

    function automatic logic [6:0] f_popcnt(input logic [BSE_WORD_W-1:0] x);
        logic [6:0] c;
        c = '0;
        for (int i = 0; i < BSE_WORD_W; i++) begin
            c = c + 7'(x[i]);
        end
        return c;
    endfunction

    function automatic logic [5:0] f_lowest(input logic [BSE_WORD_W-1:0] x);
        logic [5:0] idx;
        idx = 6'd63;
        for (int i = BSE_WORD_W - 1; i >= 0; i--) begin
            if (x[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

    // keep bits below lim within word w
    function automatic logic [BSE_WORD_W-1:0] f_mask(input logic [ADDR_W-1:0] w,
                                                     input logic [BSE_ACT_W-1:0] lim);
        logic [BSE_WORD_W-1:0] m;
        if (32'(w) < 32'(lim[10:6])) begin
            m = '1;
        end else if (32'(w) == 32'(lim[10:6])) begin
            m = (64'd1 << lim[5:0]) - 64'd1;
        end else begin
            m = '0;
        end
        return m;
    endfunction

    // a step with no source word in range feeds zeros
    assign w_cur = r_rd_ok ? i_ram_rdata : '0;

    // sweep source: k+q upward for shift down, mirrored for shift up
    assign w_sum      = SUMW'(r_k) + SUMW'(r_q);
    assign w_src_ok   = (w_sum <= SUMW'(WORD_COUNT - 1));
    assign w_src_addr = r_dir_up ? ADDR_W'(SUMW'(WORD_COUNT - 1) - w_sum) : ADDR_W'(w_sum);
    assign w_dest     = r_dir_up ? ADDR_W'(KW'(WORD_COUNT) - r_k_d) : ADDR_W'(r_k_d - KW'(1));

    always_comb begin
        if (r_dir_up) begin
            w_shift = (r_prev << r_r) | (w_cur >> (7'd64 - {1'b0, r_r}));
        end else begin
            w_shift = (r_prev >> r_r) | (w_cur << (7'd64 - {1'b0, r_r}));
        end
    end

    assign w_bit_mask = 64'd1 << r_pos[5:0];

    always_comb begin
        if (32'(r_k_d) < 32'(r_sw)) begin
            w_scan_word = '0;
        end else if (32'(r_k_d) == 32'(r_sw)) begin
            w_scan_word = i_ram_rdata & ('1 << r_sb);
        end else begin
            w_scan_word = i_ram_rdata;
        end
    end

    assign w_fpos       = {r_k_d[ADDR_W-1:0], f_lowest(w_scan_word)};
    assign w_next_start = {1'b0, r_pos} + 12'd1;

    assign o_cmd_ready = (r_state == S_IDLE) && !i_cfg_we;
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_step_v  = 1'b0;
        n_k_d     = r_k;
        n_rd_ok   = 1'b0;
        n_prev    = r_prev;
        n_res     = r_res;
        n_op      = r_op;
        n_pos     = r_pos;
        n_dir_up  = r_dir_up;
        n_q       = r_q;
        n_r       = r_r;
        n_lim     = r_lim;
        n_sw      = r_sw;
        n_sb      = r_sb;
        n_has_res = r_has_res;

        o_ram_re    = 1'b0;
        o_ram_raddr = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;

        // data of the step issued last cycle
        if (r_step_v) begin
            n_prev = w_cur;
        end
        if ((r_state == S_SWEEP) && r_step_v && (r_k_d != '0)) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = w_dest;
            o_ram_wdata = w_shift & f_mask(w_dest, r_lim);
        end
        if ((r_state == S_SCAN) && r_step_v) begin
            if (r_op == OP_COUNT) begin
                n_res.ones_count = r_res.ones_count + BSE_CNT_W'(f_popcnt(i_ram_rdata));
            end else if (!r_res.found && (w_scan_word != '0)) begin
                n_res.found          = 1'b1;
                n_res.found_position = BSE_FPOS_W'(w_fpos);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    n_op    = t_opcode'(i_opcode);
                    n_pos   = i_bit_position;
                    n_res   = '0;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_k       = '0;
                n_has_res = 1'b1;
                unique case (r_op) inside
                    OP_SET, OP_CLR, OP_FLIP, OP_TEST: begin
                        if (r_pos >= i_used) begin
                            n_res.out_of_range = 1'b1;
                            n_state            = S_DONE;
                        end else begin
                            o_ram_re    = 1'b1;
                            o_ram_raddr = ADDR_W'(r_pos[10:6]);
                            n_state     = S_BIT;
                        end
                    end
                    OP_SHL, OP_SHR: begin
                        if (r_pos >= i_used) begin
                            // long shift empties the set
                            n_dir_up = 1'b0;
                            n_q      = '0;
                            n_r      = '0;
                            n_lim    = '0;
                            n_state  = S_SWEEP;
                        end else if (r_pos == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_dir_up = (r_op == OP_SHL);
                            n_q      = r_pos[10:6];
                            n_r      = r_pos[5:0];
                            n_lim    = i_used;
                            n_state  = S_SWEEP;
                        end
                    end
                    OP_CLR_ALL: begin
                        n_dir_up = 1'b0;
                        n_q      = '0;
                        n_r      = '0;
                        n_lim    = '0;
                        n_state  = S_SWEEP;
                    end
                    OP_COUNT, OP_FIND_FST: begin
                        n_sw    = '0;
                        n_sb    = '0;
                        n_state = S_SCAN;
                    end
                    OP_FIND_NXT: begin
                        if (w_next_start >= {1'b0, i_used}) begin
                            n_state = S_DONE;
                        end else begin
                            n_sw    = w_next_start[10:6];
                            n_sb    = w_next_start[5:0];
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_BIT: begin
                unique case (r_op)
                    OP_SET: begin
                        o_ram_we    = 1'b1;
                        o_ram_wdata = i_ram_rdata | w_bit_mask;
                    end
                    OP_CLR: begin
                        o_ram_we    = 1'b1;
                        o_ram_wdata = i_ram_rdata & ~w_bit_mask;
                    end
                    OP_FLIP: begin
                        o_ram_we    = 1'b1;
                        o_ram_wdata = i_ram_rdata ^ w_bit_mask;
                    end
                    default: begin
                        n_res.bit_value = i_ram_rdata[r_pos[5:0]];
                    end
                endcase
                o_ram_waddr = ADDR_W'(r_pos[10:6]);
                n_state     = S_DONE;
            end
            S_SWEEP: begin
                if ((r_k <= KW'(WORD_COUNT)) && !i_cfg_we) begin
                    o_ram_re    = w_src_ok;
                    o_ram_raddr = w_src_addr;
                    n_step_v    = 1'b1;
                    n_k_d       = r_k;
                    n_rd_ok     = w_src_ok;
                    n_k         = r_k + KW'(1);
                end
                if (r_step_v && (r_k_d == KW'(WORD_COUNT))) begin
                    n_state = r_has_res ? S_DONE : S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_k < KW'(WORD_COUNT)) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_k[ADDR_W-1:0];
                    n_step_v    = 1'b1;
                    n_k_d       = r_k;
                    n_rd_ok     = 1'b1;
                    n_k         = r_k + KW'(1);
                end
                if (r_step_v && (r_k_d == KW'(WORD_COUNT - 1))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write: (re)start a trim pass, keeping the tighter pending limit
        if (i_cfg_we) begin
            n_state   = S_SWEEP;
            n_k       = '0;
            n_dir_up  = 1'b0;
            n_q       = '0;
            n_r       = '0;
            n_has_res = 1'b0;
            n_lim     = ((r_state == S_SWEEP) && (r_lim < i_cfg_used)) ? r_lim : i_cfg_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // power-up clearing pass: limit zero empties every word
            r_state   <= S_SWEEP;
            r_k       <= '0;
            r_step_v  <= 1'b0;
            r_dir_up  <= 1'b0;
            r_q       <= '0;
            r_r       <= '0;
            r_lim     <= '0;
            r_has_res <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_step_v  <= n_step_v;
            r_dir_up  <= n_dir_up;
            r_q       <= n_q;
            r_r       <= n_r;
            r_lim     <= n_lim;
            r_has_res <= n_has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_d   <= n_k_d;
        r_rd_ok <= n_rd_ok;
        r_prev  <= n_prev;
        r_res   <= n_res;
        r_op    <= n_op;
        r_pos   <= n_pos;
        r_sw    <= n_sw;
        r_sb    <= n_sb;
    end

endmodule

>>> sv/bitset_engine_top.sv
// Top level of the bit set engine: register, sequencer, word store, result register.
//
// Keeps a set of active_bits bits (at most N_BITS) in N_BITS/64 words of 64 bits.
// Command channel i_cmd (valid/ready) carries opcode and bit_position; each
// accepted item yields exactly one item on o_res (valid/ready), unless i_cfg_we is raised while it is in work.
// Work per command:
//   set, clear, flip, test: read-modify-write of one word
//   shift up/down, clear all: every word rewritten through the store's
//   single read and write port
//   count, find first, find next: every word read
// One item is worked on at a time; the next is accepted once the sequencer
// has handed its result to the output register, so a stalled receiver holds
// only that register and the next item still proceeds. A second result
// waits in the sequencer until the output register frees up.
// i_cfg_we writes active_bits; the store is then trimmed above the new value
// in a pass during which no item is accepted. Reset (synchronous, active low)
// sets active_bits to 1024 and runs the same pass with a limit of zero,
// clearing the store: i_cmd.ready stays low until that pass is through.
module bitset_engine_top import bse_pkg::*; #(
    parameter int N_BITS = BSE_N_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bse_cmd_if.sink              i_cmd,
    bse_res_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [BSE_ACT_W-1:0] i_cfg_wdata
);

    localparam int WORD_COUNT = (N_BITS + 63) / 64;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    logic [BSE_ACT_W-1:0]  r_active_bits, n_active_bits;
    logic                  r_out_valid, n_out_valid;
    t_res                  r_out, n_out;

    logic [BSE_ACT_W-1:0]  w_used;
    logic [BSE_ACT_W-1:0]  w_cfg_used;
    logic                  w_res_valid;
    logic                  w_res_ready;
    t_res                  w_res;

    logic                  w_ram_re;
    logic [ADDR_W-1:0]     w_ram_raddr;
    logic [BSE_WORD_W-1:0] w_ram_rdata;
    logic                  w_ram_we;
    logic [ADDR_W-1:0]     w_ram_waddr;
    logic [BSE_WORD_W-1:0] w_ram_wdata;

    // register values above capacity act as the capacity
    function automatic logic [BSE_ACT_W-1:0] f_used(input logic [BSE_ACT_W-1:0] a);
        logic [BSE_ACT_W-1:0] u;
        if (32'(a) > N_BITS) begin
            u = BSE_ACT_W'(N_BITS);
        end else begin
            u = a;
        end
        return u;
    endfunction

    assign w_used     = f_used(r_active_bits);
    assign w_cfg_used = f_used(i_cfg_wdata);

    // output register: frees whenever the receiver takes the item
    assign w_res_ready = !r_out_valid || o_res.ready;

    always_comb begin
        n_active_bits = i_cfg_we ? i_cfg_wdata : r_active_bits;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bits <= BSE_ACT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_active_bits <= n_active_bits;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.bit_value      = r_out.bit_value;
    assign o_res.ones_count     = r_out.ones_count;
    assign o_res.found          = r_out.found;
    assign o_res.found_position = r_out.found_position;
    assign o_res.out_of_range   = r_out.out_of_range;

    bse_seq #(
        .WORD_COUNT (WORD_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_cmd.valid),
        .o_cmd_ready    (i_cmd.ready),
        .i_opcode       (i_cmd.opcode),
        .i_bit_position (i_cmd.bit_position),
        .i_used         (w_used),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_used     (w_cfg_used),
        .o_res_valid    (w_res_valid),
        .i_res_ready    (w_res_ready),
        .o_res          (w_res),
        .o_ram_re       (w_ram_re),
        .o_ram_raddr    (w_ram_raddr),
        .i_ram_rdata    (w_ram_rdata),
        .o_ram_we       (w_ram_we),
        .o_ram_waddr    (w_ram_waddr),
        .o_ram_wdata    (w_ram_wdata)
    );

    bse_ram #(
        .DEPTH  (WORD_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata)
    );

endmodule

>>> sv/bse_chk.sv
// Port-level checks of the bit set engine and their binding to the top level.
module bse_chk import bse_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cmd_valid,
    input logic                  i_cmd_ready,
    input logic                  i_res_valid,
    input logic                  i_res_ready,
    input logic                  i_res_bit_value,
    input logic [BSE_CNT_W-1:0]  i_res_ones_count,
    input logic                  i_res_found,
    input logic [BSE_FPOS_W-1:0] i_res_found_position,
    input logic                  i_res_out_of_range,
    input logic                  i_cfg_we
);

    // a result item stays offered until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // each command reports through at most one field
    a_res_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> $onehot0({i_res_bit_value, i_res_found, i_res_out_of_range,
                                  |i_res_ones_count}))
        else $error("more than one result field active");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_found |-> i_res_found_position == '0)
        else $error("position reported without a find");

    // one item at a time: the sequencer is busy right after accepting
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("item accepted while previous still in work");

    // a register write starts the trim pass
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_cmd_ready)
        else $error("item accepted during trim pass");

endmodule

bind bitset_engine_top bse_chk u_bse_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_cmd_valid          (i_cmd.valid),
    .i_cmd_ready          (i_cmd.ready),
    .i_res_valid          (o_res.valid),
    .i_res_ready          (o_res.ready),
    .i_res_bit_value      (o_res.bit_value),
    .i_res_ones_count     (o_res.ones_count),
    .i_res_found          (o_res.found),
    .i_res_found_position (o_res.found_position),
    .i_res_out_of_range   (o_res.out_of_range),
    .i_cfg_we             (i_cfg_we)
);

>>> test/bse_checker.sv
// Checker for the bit set engine: watches both channels, predicts each result and compares.
module bse_checker import bse_pkg::*; #(
    parameter int N_BITS = BSE_N_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bse_cmd_if                   i_cmd,
    bse_res_if                   i_res,
    input  logic                 i_cfg_we,
    input  logic [BSE_ACT_W-1:0] i_cfg_wdata,
    output int                   o_pending,
    output int                   o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [N_BITS-1:0]    set_bits;    // predicted contents of the set
    logic [BSE_ACT_W-1:0] act_bits;    // predicted active_bits register
    t_res                 want_q[$];   // results still owed by the block

    function automatic int live_width();
        return (act_bits > N_BITS) ? N_BITS : int'(act_bits);
    endfunction

    // ones in positions below n
    function automatic logic [N_BITS-1:0] low_mask(input int n);
        logic [N_BITS-1:0] m;
        m = '1;
        m = m << n;
        return ~m;
    endfunction

    // lowest one at or above start, -1 when there is none
    function automatic int seek_one(input int start);
        int i;
        for (i = start; i < N_BITS; i++)
            if (set_bits[i]) return i;
        return -1;
    endfunction

    function automatic t_res apply_item(input logic [BSE_OP_W-1:0] op,
                                        input logic [BSE_POS_W-1:0] p);
        t_res r;
        int   n;
        int   hit;
        r   = '0;
        n   = live_width();
        hit = -1;
        case (op)
            OP_SET, OP_CLR, OP_FLIP, OP_TEST: begin
                if (int'(p) >= n) begin
                    r.out_of_range = 1'b1;
                end else if (op == OP_SET) begin
                    set_bits[p] = 1'b1;
                end else if (op == OP_CLR) begin
                    set_bits[p] = 1'b0;
                end else if (op == OP_FLIP) begin
                    set_bits[p] = ~set_bits[p];
                end else begin
                    r.bit_value = set_bits[p];
                end
            end
            OP_SHL, OP_SHR: begin
                if (int'(p) >= n)
                    set_bits = '0;
                else if (op == OP_SHL)
                    set_bits = (set_bits << p) & low_mask(n);
                else
                    set_bits = (set_bits >> p) & low_mask(n);
            end
            OP_CLR_ALL:  set_bits = '0;
            OP_COUNT:    r.ones_count = BSE_CNT_W'($countones(set_bits));
            OP_FIND_FST: hit = seek_one(0);
            OP_FIND_NXT: if (int'(p) + 1 < n) hit = seek_one(int'(p) + 1);
            default: ;  // undefined codes leave everything alone
        endcase
        if (hit >= 0) begin
            r.found          = 1'b1;
            r.found_position = BSE_FPOS_W'(hit);
        end
        return r;
    endfunction

    task automatic flag(input string field, input int want, input int got);
        $display("%0t: result mismatch on %s: expected %0d, actual %0d",
                 $time, field, want, got);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            set_bits = '0;
            act_bits = BSE_ACT_RST;
            want_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.bit_value      = i_res.bit_value;
                got.ones_count     = i_res.ones_count;
                got.found          = i_res.found;
                got.found_position = i_res.found_position;
                got.out_of_range   = i_res.out_of_range;
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected result item: expected none, actual %h",
                             $time, got);
                    o_fail_count++;
                end else begin
                    want = want_q.pop_front();
                    if (got.bit_value !== want.bit_value)
                        flag("bit_value", want.bit_value, got.bit_value);
                    if (got.ones_count !== want.ones_count)
                        flag("ones_count", want.ones_count, got.ones_count);
                    if (got.found !== want.found)
                        flag("found", want.found, got.found);
                    if (got.found_position !== want.found_position)
                        flag("found_position", want.found_position, got.found_position);
                    if (got.out_of_range !== want.out_of_range)
                        flag("out_of_range", want.out_of_range, got.out_of_range);
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                want_q.push_back(apply_item(i_cmd.opcode, i_cmd.bit_position));
            if (i_cfg_we) begin
                act_bits = i_cfg_wdata;
                set_bits = set_bits & low_mask(live_width());
            end
        end
        o_pending <= want_q.size();
    end

endmodule

>>> test/tb_top.sv
// Testbench top of the bit set engine: clock, reset, stimulus and verdict.
module tb_top import bse_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Watchdog bound on the length of the whole run.
    localparam int LIMIT_CYCLES = 400_000;
    localparam int PHASE_ITEMS  = 60;    // random items per register setting
    localparam int HOLD_AT      = 150;   // result count that starts the long stall
    localparam int HOLD_CYCLES  = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [BSE_ACT_W-1:0] cfg_wdata;

    int chk_pending;     // results the checker is still waiting for
    int chk_fails;
    int cycles;
    int items_sent;
    int results_seen;
    int settings_used;
    int cur_act;         // active_bits as last written, for shaping positions
    bit calm;            // set near the end: no idling on either side

    bse_cmd_if cmd_if ();
    bse_res_if res_if ();

    bitset_engine_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    bse_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (chk_pending),
        .o_fail_count (chk_fails)
    );

    // 8 ns clock
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("bitset_engine_top regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sender helpers
    // ---------------------------------------------------------------

    // Drop valid and hold it low for a span set by n.
    task automatic pause_sender(input int n);
        cmd_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Offer one item and return at the edge that accepts it; valid is left
    // high so a back-to-back item costs no bubble.
    task automatic send_item(input logic [BSE_OP_W-1:0] op, input logic [BSE_POS_W-1:0] pos);
        cmd_if.valid        <= 1'b1;
        cmd_if.opcode       <= op;
        cmd_if.bit_position <= pos;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        items_sent++;
        if (!calm && $urandom_range(0, 4) == 0)
            pause_sender($urandom_range(1, 8));
    endtask

    // Stop sending until every result is back. The checker's count is
    // registered, so it is trusted only from the next edge on.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called with the block idle; the trim pass that follows shows up
    // as ready held low on the next item.
    task automatic write_active(input logic [BSE_ACT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_act = int'(value);
        settings_used++;
    endtask

    // Mostly legal positions, some right at the edge of the active range,
    // the rest anywhere in the 11-bit field.
    function automatic logic [BSE_POS_W-1:0] pick_position();
        int n;
        int r;
        n = (cur_act > BSE_N_BITS_DEF) ? BSE_N_BITS_DEF : cur_act;
        r = $urandom_range(0, 99);
        if (r < 70 && n > 0) return BSE_POS_W'($urandom_range(0, n - 1));
        if (r < 85) return BSE_POS_W'(n - 1 + int'($urandom_range(0, 2)));
        return BSE_POS_W'($urandom_range(0, 2047));
    endfunction

    // Weighted toward setting bits so finds and shifts have something to chew on;
    // clear-all is rare and undefined codes show up now and then.
    task automatic send_random();
        logic [BSE_OP_W-1:0]  op;
        logic [BSE_POS_W-1:0] pos;
        int                   r;
        r = $urandom_range(0, 99);
        if      (r < 25) op = OP_SET;
        else if (r < 32) op = OP_CLR;
        else if (r < 42) op = OP_FLIP;
        else if (r < 55) op = OP_TEST;
        else if (r < 61) op = OP_SHL;
        else if (r < 67) op = OP_SHR;
        else if (r < 69) op = OP_CLR_ALL;
        else if (r < 77) op = OP_COUNT;
        else if (r < 83) op = OP_FIND_FST;
        else if (r < 93) op = OP_FIND_NXT;
        else             op = BSE_OP_W'($urandom_range(10, 15));
        // short shifts keep the set populated
        if ((op == OP_SHL || op == OP_SHR) && $urandom_range(0, 9) < 6)
            pos = BSE_POS_W'($urandom_range(0, 8));
        else
            pos = pick_position();
        send_item(op, pos);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off, none when calm
    // ---------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready) results_seen++;
            if (!hold_done && results_seen >= HOLD_AT) begin
                // sender keeps offering, so the engine fills and blocks its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int plan[10];
        int ph;
        int k;
        // register settings, extremes included; 1024 first is the reset value
        plan = '{1024, 1, 0, 2047, 64, 65, 700, 1023, 0, 1024};
        plan[8] = $urandom_range(2, 1000);
        items_sent    = 0;
        settings_used = 0;
        cur_act       = int'(BSE_ACT_RST);
        calm          = 1'b0;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        cmd_if.valid        <= 1'b0;
        cmd_if.opcode       <= '0;
        cmd_if.bit_position <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty set, both ends of the range, out-of-range positions,
        // finds at the end, zero and long shifts, undefined codes.
        send_item(OP_TEST, 0);
        send_item(OP_SET, 0);
        send_item(OP_SET, 1023);
        send_item(OP_SET, 63);
        send_item(OP_SET, 64);
        send_item(OP_TEST, 1023);
        send_item(OP_SET, 1024);
        send_item(OP_FLIP, 2047);
        send_item(OP_TEST, 1500);
        send_item(OP_CLR, 63);
        send_item(OP_COUNT, 0);
        send_item(OP_FIND_FST, 0);
        send_item(OP_FIND_NXT, 1022);
        send_item(OP_FIND_NXT, 1023);
        send_item(OP_FLIP, 5);
        send_item(OP_TEST, 5);
        send_item(OP_SHL, 0);
        send_item(OP_SHL, 1);
        send_item(OP_SHR, 1);
        send_item(OP_COUNT, 0);
        send_item(BSE_OP_W'(10), 2047);
        send_item(OP_SHR, 1024);
        send_item(OP_FIND_FST, 0);
        send_item(OP_SHL, 2047);
        send_item(OP_CLR_ALL, 0);

        // Random phases, one per register setting. Each boundary drains the
        // engine first, which is also the sender's full pause.
        for (ph = 0; ph < 10; ph++) begin
            wait_drained();
            if (ph > 0) begin
                write_active(BSE_ACT_W'(plan[ph]));
                // see the trim of the store first
                send_item(OP_COUNT, 0);
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 9 && k >= PHASE_ITEMS / 3) calm = 1'b1;
                send_random();
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Covered %0d command items and %0d results over %0d register writes,",
                 items_sent, results_seen, settings_used);
        $display("with random stalls on both sides and one %0d-cycle receiver hold-off.",
                 HOLD_CYCLES);
        if (chk_fails == 0 && chk_pending == 0)
            $display("bitset_engine_top regression: pass");
        else
            $display("bitset_engine_top regression: fail");
        $finish;
    end

endmodule
